@@ sv/dic_pkg.sv @@
package dic_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_HI_LIMIT   = 3'd0;
  localparam logic [2:0] REG_OPEN_LEVEL = 3'd1;
  localparam logic [2:0] REG_BTN_DEB    = 3'd2;
  localparam logic [2:0] REG_FLOW_DEB   = 3'd3;
  localparam logic [2:0] REG_HEAT_DEB   = 3'd4;
  localparam logic [2:0] REG_FAST_FLASH = 3'd5;
  localparam logic [2:0] REG_SLOW_FLASH = 3'd6;

  localparam logic [9:0]  HI_LIMIT_RST   = 10'd450;
  localparam logic [9:0]  OPEN_LEVEL_RST = 10'd900;
  localparam logic [15:0] BTN_DEB_RST    = 16'd50;
  localparam logic [15:0] FLOW_DEB_RST   = 16'd500;
  localparam logic [15:0] HEAT_DEB_RST   = 16'd500;
  localparam logic [15:0] FAST_FLASH_RST = 16'd250;
  localparam logic [15:0] SLOW_FLASH_RST = 16'd1000;

  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_NO_FLOW = 2'd1;
  localparam logic [1:0] FAULT_LOCKED  = 2'd2;

  typedef struct packed {
    logic        stable;
    logic        prev;
    logic [31:0] stamp;
    logic        changed;
  } deb_t;

  typedef struct packed {
    logic        led;
    logic [31:0] stamp;
  } flash_t;

  // Level debouncer: restamp on a raw edge, adopt the raw level once it has held long enough.
  function automatic deb_t debounce(input logic raw, input logic stable, input logic prev,
                                    input logic [31:0] stamp, input logic [31:0] now,
                                    input logic [15:0] hold);
    deb_t r;
    r.prev    = raw;
    r.stamp   = (raw != prev) ? now : stamp;
    r.stable  = stable;
    r.changed = 1'b0;
    if (((now - r.stamp) > {16'd0, hold}) && (raw != stable)) begin
      r.stable  = raw;
      r.changed = 1'b1;
    end
    return r;
  endfunction

  function automatic flash_t flash(input logic led, input logic [31:0] stamp,
                                   input logic [31:0] now, input logic [15:0] period);
    flash_t r;
    r.led   = led;
    r.stamp = stamp;
    if ((now - stamp) > {16'd0, period}) begin
      r.led   = ~led;
      r.stamp = now;
    end
    return r;
  endfunction

endpackage

@@ sv/dic_ifs.sv @@
interface dic_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        light_button;
  logic        jets_button;
  logic        heat_level;
  logic        flow_level;
  logic [9:0]  limit_sample;

  modport source (output valid, output now_ms, output light_button, output jets_button,
                  output heat_level, output flow_level, output limit_sample, input ready);
  modport sink   (input valid, input now_ms, input light_button, input jets_button,
                  input heat_level, input flow_level, input limit_sample, output ready);
endinterface

interface dic_out_if;
  logic       valid;
  logic       ready;
  logic       light_drive;
  logic       jets_drive;
  logic       heat_drive;
  logic       status_light;
  logic       lockout_flag;
  logic [1:0] fault_code;

  modport source (output valid, output light_drive, output jets_drive, output heat_drive,
                  output status_light, output lockout_flag, output fault_code, input ready);
  modport sink   (input valid, input light_drive, input jets_drive, input heat_drive,
                  input status_light, input lockout_flag, input fault_code, output ready);
endinterface

@@ sv/debounced_interlock_controller.sv @@
// Channel   Role    Handshake       Payload
// in_if     sink    valid/ready     now_ms, four raw levels, limit_sample
// out_if    source  valid/ready     three drive pins, status_light, lockout_flag, fault_code
// cfg_*     slave   APB write/read  seven registers at byte address 4*index
//
// From input transaction to result: input register, then the control pass
// (debounce, flash and limit compares) into the result register.
// One transaction per cycle unless out_if stalls; the pass state loads with the result.
// A stalled output holds the result; the input register fills behind it, then in_if.ready drops.
// rst_n (synchronous) restores register defaults and the controller state.
module debounced_interlock_controller import dic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dic_in_if.sink                in_if,
  dic_out_if.source             out_if,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // configuration registers
  logic [9:0]  hi_limit_r, open_level_r;
  logic [15:0] btn_deb_r, flow_deb_r, heat_deb_r, fast_flash_r, slow_flash_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_limit_r   <= HI_LIMIT_RST;
      open_level_r <= OPEN_LEVEL_RST;
      btn_deb_r    <= BTN_DEB_RST;
      flow_deb_r   <= FLOW_DEB_RST;
      heat_deb_r   <= HEAT_DEB_RST;
      fast_flash_r <= FAST_FLASH_RST;
      slow_flash_r <= SLOW_FLASH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HI_LIMIT:   hi_limit_r   <= cfg_pwdata[9:0];
        REG_OPEN_LEVEL: open_level_r <= cfg_pwdata[9:0];
        REG_BTN_DEB:    btn_deb_r    <= cfg_pwdata[15:0];
        REG_FLOW_DEB:   flow_deb_r   <= cfg_pwdata[15:0];
        REG_HEAT_DEB:   heat_deb_r   <= cfg_pwdata[15:0];
        REG_FAST_FLASH: fast_flash_r <= cfg_pwdata[15:0];
        REG_SLOW_FLASH: slow_flash_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HI_LIMIT:   cfg_prdata = {22'd0, hi_limit_r};
      REG_OPEN_LEVEL: cfg_prdata = {22'd0, open_level_r};
      REG_BTN_DEB:    cfg_prdata = {16'd0, btn_deb_r};
      REG_FLOW_DEB:   cfg_prdata = {16'd0, flow_deb_r};
      REG_HEAT_DEB:   cfg_prdata = {16'd0, heat_deb_r};
      REG_FAST_FLASH: cfg_prdata = {16'd0, fast_flash_r};
      REG_SLOW_FLASH: cfg_prdata = {16'd0, slow_flash_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // input register
  logic        in_v_r;
  logic [31:0] now_r;
  logic        light_raw_r, jets_raw_r, heat_raw_r, flow_raw_r;
  logic [9:0]  sample_r;
  logic        advance;

  logic        out_v_r;

  assign advance     = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      now_r       <= in_if.now_ms;
      light_raw_r <= in_if.light_button;
      jets_raw_r  <= in_if.jets_button;
      heat_raw_r  <= in_if.heat_level;
      flow_raw_r  <= in_if.flow_level;
      sample_r    <= in_if.limit_sample;
    end
  end

  // controller state
  logic        lockout_r, lockout_nxt;
  logic        light_tog_r, light_tog_nxt;
  logic        jets_tog_r, jets_tog_nxt;
  deb_t        light_deb_r, light_deb_nxt;
  deb_t        jets_deb_r, jets_deb_nxt;
  deb_t        flow_deb_st_r, flow_deb_st_nxt;
  deb_t        heat_deb_st_r, heat_deb_st_nxt;
  logic [31:0] flash_stamp_r, flash_stamp_nxt;
  logic [3:0]  pins_r, pins_nxt;   // {led, heat, jets, light}
  logic [1:0]  fault;

  logic [10:0] temp;
  logic        limit_trip;
  deb_t        flow_d, heat_d, jets_d, light_d;
  flash_t      fl;

  assign temp       = {1'b0, open_level_r} - {1'b0, sample_r};
  assign limit_trip = temp[10] || (temp[9:0] > hi_limit_r);

  always_comb begin
    lockout_nxt     = lockout_r;
    light_tog_nxt   = light_tog_r;
    jets_tog_nxt    = jets_tog_r;
    light_deb_nxt   = light_deb_r;
    jets_deb_nxt    = jets_deb_r;
    flow_deb_st_nxt = flow_deb_st_r;
    heat_deb_st_nxt = heat_deb_st_r;
    flash_stamp_nxt = flash_stamp_r;
    pins_nxt        = pins_r;
    fault           = FAULT_LOCKED;

    flow_d  = debounce(flow_raw_r, flow_deb_st_r.stable, flow_deb_st_r.prev,
                       flow_deb_st_r.stamp, now_r, flow_deb_r);
    heat_d  = debounce(heat_raw_r, heat_deb_st_r.stable, heat_deb_st_r.prev,
                       heat_deb_st_r.stamp, now_r, heat_deb_r);
    jets_d  = debounce(jets_raw_r, jets_deb_r.stable, jets_deb_r.prev,
                       jets_deb_r.stamp, now_r, btn_deb_r);
    light_d = debounce(light_raw_r, light_deb_r.stable, light_deb_r.prev,
                       light_deb_r.stamp, now_r, btn_deb_r);
    fl      = flash(pins_r[3], flash_stamp_r, now_r, lockout_r ? slow_flash_r : fast_flash_r);

    if (lockout_r) begin
      pins_nxt        = {fl.led, 3'b111};
      flash_stamp_nxt = fl.stamp;
    end else if (limit_trip) begin
      // latching pass: pins hold
      lockout_nxt = 1'b1;
    end else begin
      flow_deb_st_nxt = flow_d;
      if (flow_d.stable) begin
        jets_tog_nxt           = 1'b1;
        heat_deb_st_nxt.stable = 1'b1;
        fault                  = FAULT_NO_FLOW;
      end else begin
        heat_deb_st_nxt = heat_d;
        jets_deb_nxt    = jets_d;
        jets_tog_nxt    = jets_tog_r ^ (jets_d.changed && !jets_d.stable);
        fault           = FAULT_NONE;
      end
      light_deb_nxt = light_d;
      light_tog_nxt = light_tog_r ^ (light_d.changed && !light_d.stable);
      pins_nxt[0]   = light_tog_nxt;
      pins_nxt[1]   = jets_tog_nxt;
      pins_nxt[2]   = heat_deb_st_nxt.stable;
      if (fault == FAULT_NO_FLOW) begin
        pins_nxt[3]     = fl.led;
        flash_stamp_nxt = fl.stamp;
      end else begin
        pins_nxt[3] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r     <= 1'b0;
      light_tog_r   <= 1'b1;
      jets_tog_r    <= 1'b1;
      light_deb_r   <= '{stable: 1'b1, prev: 1'b1, stamp: 32'd0, changed: 1'b0};
      jets_deb_r    <= '{stable: 1'b1, prev: 1'b1, stamp: 32'd0, changed: 1'b0};
      flow_deb_st_r <= '{stable: 1'b1, prev: 1'b1, stamp: 32'd0, changed: 1'b0};
      heat_deb_st_r <= '{stable: 1'b1, prev: 1'b1, stamp: 32'd0, changed: 1'b0};
      flash_stamp_r <= 32'd0;
      pins_r        <= 4'b0111;
    end else if (advance) begin
      lockout_r     <= lockout_nxt;
      light_tog_r   <= light_tog_nxt;
      jets_tog_r    <= jets_tog_nxt;
      light_deb_r   <= light_deb_nxt;
      jets_deb_r    <= jets_deb_nxt;
      flow_deb_st_r <= flow_deb_st_nxt;
      heat_deb_st_r <= heat_deb_st_nxt;
      flash_stamp_r <= flash_stamp_nxt;
      pins_r        <= pins_nxt;
    end
  end

  // result register
  logic [3:0] out_pins_r;
  logic       out_lock_r;
  logic [1:0] out_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pins_r  <= pins_nxt;
      out_lock_r  <= lockout_nxt;
      out_fault_r <= fault;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.light_drive  = out_pins_r[0];
  assign out_if.jets_drive   = out_pins_r[1];
  assign out_if.heat_drive   = out_pins_r[2];
  assign out_if.status_light = out_pins_r[3];
  assign out_if.lockout_flag = out_lock_r;
  assign out_if.fault_code   = out_fault_r;

endmodule

@@ sim/tb_top.sv @@
module tb_top import dic_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED  = 3'd7;
  localparam int         CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        light;
    logic        jets;
    logic        heat;
    logic        flow;
    logic [9:0]  sample;
  } pass_t;

  typedef struct packed {
    logic       light;
    logic       jets;
    logic       heat;
    logic       status;
    logic       locked;
    logic [1:0] fault;
  } drive_t;

  typedef struct {
    pass_t  item;
    bit     pinned;
    drive_t want;
    bit     regroup;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  dic_in_if  in_if ();
  dic_out_if out_if ();

  debounced_interlock_controller i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Controller state as the testbench sees it
  logic [31:0] reg_val [7];
  logic        locked;
  logic        light_tog, light_stab, light_prev;
  logic [31:0] light_stamp;
  logic        jets_tog, jets_stab, jets_prev;
  logic [31:0] jets_stamp;
  logic        flow_stab, flow_prev;
  logic [31:0] flow_stamp;
  logic        heat_stab, heat_prev;
  logic [31:0] heat_stamp;
  logic [31:0] flash_stamp;
  logic        light_pin, jets_pin, heat_pin, led_pin;

  drive_t      expected_drives [$];
  row_t        table_rows [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          stall_left = 0;
  bit          pin_next = 1'b0;
  drive_t      pin_drive;
  logic [31:0] now_cursor = '0;
  logic        lv_light = 1'b1, lv_jets = 1'b1, lv_heat = 1'b1, lv_flow = 1'b1;

  task automatic note_error(input string msg);
    $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic settle(input logic raw, inout logic stab, inout logic prev,
                        inout logic [31:0] stamp, input logic [31:0] now,
                        input logic [31:0] hold, output logic moved);
    logic [31:0] held;
    if (raw != prev) stamp = now;
    held  = now - stamp;
    moved = (held > hold) && (raw != stab);
    if (moved) stab = raw;
    prev = raw;
  endtask

  task automatic blink(input logic [31:0] now, input logic [31:0] period);
    logic [31:0] held;
    held = now - flash_stamp;
    if (held > period) begin
      led_pin     = ~led_pin;
      flash_stamp = now;
    end
  endtask

  task automatic step_controller(input pass_t p, output drive_t d);
    int         margin;
    logic       moved;
    logic [1:0] fault;
    if (locked) begin
      light_pin = 1'b1;
      jets_pin  = 1'b1;
      heat_pin  = 1'b1;
      blink(p.now_ms, reg_val[REG_SLOW_FLASH]);
      fault = FAULT_LOCKED;
    end else begin
      margin = int'(reg_val[REG_OPEN_LEVEL]) - int'(p.sample);
      if (margin < 0 || margin > int'(reg_val[REG_HI_LIMIT])) begin
        // the latching pass leaves every pin where it was
        locked = 1'b1;
        fault  = FAULT_LOCKED;
      end else begin
        settle(p.flow, flow_stab, flow_prev, flow_stamp, p.now_ms, reg_val[REG_FLOW_DEB], moved);
        if (flow_stab) begin
          // no flow: heat and jets debouncers are not sampled
          jets_tog  = 1'b1;
          heat_stab = 1'b1;
          fault     = FAULT_NO_FLOW;
        end else begin
          settle(p.heat, heat_stab, heat_prev, heat_stamp, p.now_ms, reg_val[REG_HEAT_DEB],
                 moved);
          settle(p.jets, jets_stab, jets_prev, jets_stamp, p.now_ms, reg_val[REG_BTN_DEB],
                 moved);
          if (moved && !jets_stab) jets_tog = ~jets_tog;
          fault = FAULT_NONE;
        end
        settle(p.light, light_stab, light_prev, light_stamp, p.now_ms, reg_val[REG_BTN_DEB],
               moved);
        if (moved && !light_stab) light_tog = ~light_tog;
        light_pin = light_tog;
        jets_pin  = jets_tog;
        heat_pin  = heat_stab;
        if (fault == FAULT_NO_FLOW) blink(p.now_ms, reg_val[REG_FAST_FLASH]);
        else led_pin = 1'b1;
      end
    end
    d.light  = light_pin;
    d.jets   = jets_pin;
    d.heat   = heat_pin;
    d.status = led_pin;
    d.locked = locked;
    d.fault  = fault;
  endtask

  function automatic int idle_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    return ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
  endfunction

  function automatic logic [31:0] junk_high(int v);
    return ($urandom() & 32'hFFFF_0000) | v;
  endfunction

  function automatic row_t dir_row(logic [31:0] now, logic lt, logic jt, logic ht,
                                   logic fl, logic [9:0] s);
    row_t r;
    r.item    = {now, lt, jt, ht, fl, s};
    r.pinned  = 1'b0;
    r.want    = '0;
    r.regroup = 1'b0;
    return r;
  endfunction

  // Scoreboard: predict on input transactions, compare on output transactions
  always @(posedge clk) begin : watch
    drive_t got;
    drive_t want;
    pass_t  item;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        got = {out_if.light_drive, out_if.jets_drive, out_if.heat_drive, out_if.status_light,
               out_if.lockout_flag, out_if.fault_code};
        if (expected_drives.size() == 0) begin
          note_error("result with nothing expected");
        end else begin
          want = expected_drives.pop_front();
          if (got.light !== want.light)
            note_error($sformatf("light_drive %b, expected %b", got.light, want.light));
          if (got.jets !== want.jets)
            note_error($sformatf("jets_drive %b, expected %b", got.jets, want.jets));
          if (got.heat !== want.heat)
            note_error($sformatf("heat_drive %b, expected %b", got.heat, want.heat));
          if (got.status !== want.status)
            note_error($sformatf("status_light %b, expected %b", got.status, want.status));
          if (got.locked !== want.locked)
            note_error($sformatf("lockout_flag %b, expected %b", got.locked, want.locked));
          if (got.fault !== want.fault)
            note_error($sformatf("fault_code %0d, expected %0d", got.fault, want.fault));
        end
      end
      if (in_if.valid && in_if.ready) begin
        item = {in_if.now_ms, in_if.light_button, in_if.jets_button, in_if.heat_level,
                in_if.flow_level, in_if.limit_sample};
        step_controller(item, want);
        if (pin_next) want = pin_drive;
        expected_drives.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_if.ready <= 1'b0;
      stall_left = idle_len(100) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_pass(input pass_t p, input bit pinned, input drive_t want);
    int gap;
    gap = idle_len(gap_pct);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pin_next  = pinned;
    pin_drive = want;
    in_if.valid        <= 1'b1;
    in_if.now_ms       <= p.now_ms;
    in_if.light_button <= p.light;
    in_if.jets_button  <= p.jets;
    in_if.heat_level   <= p.heat;
    in_if.flow_level   <= p.flow;
    in_if.limit_sample <= p.sample;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    now_cursor = p.now_ms;
  endtask

  // Hold off the sender until every outstanding transaction has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (expected_drives.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    logic [31:0] kept;
    kept = (idx == REG_HI_LIMIT || idx == REG_OPEN_LEVEL) ? {22'd0, data[9:0]}
                                                          : {16'd0, data[15:0]};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    if (idx != REG_UNUSED) begin
      reg_val[idx] = kept;
      // read back the register just written
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      @(negedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      if (cfg_prdata !== kept)
        note_error($sformatf("register %0d reads %h, expected %h", idx, cfg_prdata, kept));
      @(negedge clk);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [31:0] hi, input logic [31:0] open,
                          input logic [31:0] btn, input logic [31:0] flow,
                          input logic [31:0] heat, input logic [31:0] fast,
                          input logic [31:0] slow);
    cfg_write(REG_HI_LIMIT, hi);
    cfg_write(REG_OPEN_LEVEL, open);
    cfg_write(REG_BTN_DEB, btn);
    cfg_write(REG_FLOW_DEB, flow);
    cfg_write(REG_HEAT_DEB, heat);
    cfg_write(REG_FAST_FLASH, fast);
    cfg_write(REG_SLOW_FLASH, slow);
  endtask

  task automatic walk_rows();
    foreach (table_rows[k]) begin
      if (table_rows[k].regroup) begin
        drain();
        // out-of-range limits, zero and full-scale timing
        set_regs(1023, 1023, 0, 65535, 0, 65535, 0);
        cfg_write(REG_UNUSED, 32'hDEAD_BEEF);
      end
      send_pass(table_rows[k].item, table_rows[k].pinned, table_rows[k].want);
    end
    table_rows.delete();
  endtask

  task automatic run_random(int count, int step_max, int flip_div, bit lock_ok);
    pass_t p;
    int    lo;
    int    open_v;
    repeat (count) begin
      if ($urandom_range(99) == 0) drain();
      p.now_ms = ($urandom_range(59) == 0) ? $urandom() : now_cursor + $urandom_range(step_max);
      if ($urandom_range(flip_div - 1) == 0) lv_light = ~lv_light;
      if ($urandom_range(flip_div - 1) == 0) lv_jets = ~lv_jets;
      if ($urandom_range(flip_div - 1) == 0) lv_heat = ~lv_heat;
      // keep flow mostly present so the button and heat paths stay reachable
      if ($urandom_range(lv_flow ? 3 : 24) == 0) lv_flow = ~lv_flow;
      p.light = lv_light;
      p.jets  = lv_jets;
      p.heat  = lv_heat;
      p.flow  = lv_flow;
      open_v = int'(reg_val[REG_OPEN_LEVEL]);
      lo     = open_v - int'(reg_val[REG_HI_LIMIT]);
      if (lo < 0) lo = 0;
      case ($urandom_range(7))
        0:       p.sample = 10'(lo);
        1:       p.sample = 10'(open_v);
        default: p.sample = 10'($urandom_range(open_v, lo));
      endcase
      if (lock_ok) p.sample = 10'($urandom_range(1023));
      send_pass(p, 1'b0, '0);
    end
  endtask

  initial begin
    row_t r;
    rst_n              = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    in_if.valid        = 1'b0;
    in_if.now_ms       = '0;
    in_if.light_button = 1'b1;
    in_if.jets_button  = 1'b1;
    in_if.heat_level   = 1'b1;
    in_if.flow_level   = 1'b1;
    in_if.limit_sample = '0;
    out_if.ready       = 1'b0;

    reg_val[REG_HI_LIMIT]   = HI_LIMIT_RST;
    reg_val[REG_OPEN_LEVEL] = OPEN_LEVEL_RST;
    reg_val[REG_BTN_DEB]    = BTN_DEB_RST;
    reg_val[REG_FLOW_DEB]   = FLOW_DEB_RST;
    reg_val[REG_HEAT_DEB]   = HEAT_DEB_RST;
    reg_val[REG_FAST_FLASH] = FAST_FLASH_RST;
    reg_val[REG_SLOW_FLASH] = SLOW_FLASH_RST;
    locked      = 1'b0;
    light_tog   = 1'b1; light_stab = 1'b1; light_prev = 1'b1; light_stamp = '0;
    jets_tog    = 1'b1; jets_stab  = 1'b1; jets_prev  = 1'b1; jets_stamp  = '0;
    flow_stab   = 1'b1; flow_prev  = 1'b1; flow_stamp = '0;
    heat_stab   = 1'b1; heat_prev  = 1'b1; heat_stamp = '0;
    flash_stamp = '0;
    light_pin   = 1'b1; jets_pin = 1'b1; heat_pin = 1'b1; led_pin = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed passes at reset settings: flow, heat and both buttons, then wraparound
    r = dir_row(32'd0, 1, 1, 1, 1, 10'd450);
    r.pinned = 1'b1;
    r.want   = {1'b1, 1'b1, 1'b1, 1'b0, 1'b0, FAULT_NO_FLOW};
    table_rows.push_back(r);
    r = dir_row(32'd251, 1, 1, 1, 1, 10'd900);
    r.pinned = 1'b1;
    r.want   = {1'b1, 1'b1, 1'b1, 1'b1, 1'b0, FAULT_NO_FLOW};
    table_rows.push_back(r);
    table_rows.push_back(dir_row(32'd300, 1, 1, 1, 0, 10'd600));
    table_rows.push_back(dir_row(32'd801, 1, 1, 1, 0, 10'd600));
    table_rows.push_back(dir_row(32'd810, 0, 1, 1, 0, 10'd700));
    table_rows.push_back(dir_row(32'd861, 0, 1, 1, 0, 10'd700));
    table_rows.push_back(dir_row(32'd870, 1, 0, 1, 0, 10'd500));
    table_rows.push_back(dir_row(32'd925, 1, 0, 1, 0, 10'd500));
    table_rows.push_back(dir_row(32'd930, 1, 0, 0, 0, 10'd451));
    table_rows.push_back(dir_row(32'd1431, 1, 0, 0, 0, 10'd451));
    table_rows.push_back(dir_row(32'd1500, 1, 1, 0, 1, 10'd800));
    table_rows.push_back(dir_row(32'd2001, 1, 1, 0, 1, 10'd800));
    table_rows.push_back(dir_row(32'd2100, 0, 1, 1, 1, 10'd650));
    table_rows.push_back(dir_row(32'd2200, 0, 1, 1, 1, 10'd650));
    table_rows.push_back(dir_row(32'hFFFF_FFF0, 1, 1, 1, 0, 10'd600));
    table_rows.push_back(dir_row(32'h0000_0400, 1, 1, 1, 0, 10'd600));
    // sample extremes and zero debounce under out-of-range limits
    r = dir_row(32'hFFFF_FFFF, 0, 0, 0, 0, 10'd0);
    r.regroup = 1'b1;
    table_rows.push_back(r);
    table_rows.push_back(dir_row(32'h0000_0000, 0, 0, 0, 0, 10'd1023));
    table_rows.push_back(dir_row(32'd1, 1, 1, 1, 0, 10'd1023));
    table_rows.push_back(dir_row(32'd1, 0, 0, 0, 0, 10'd0));
    table_rows.push_back(dir_row(32'd3, 0, 0, 0, 0, 10'h2AA));
    table_rows.push_back(dir_row(32'd5, 1, 1, 1, 0, 10'h155));
    gap_pct   = 25;
    stall_pct = 25;
    walk_rows();

    // Random phases, one setting each
    drain();
    set_regs(450, 900, 50, 500, 500, 250, 1000);
    gap_pct   = 30;
    stall_pct = 30;
    run_random(200, 60, 6, 1'b0);

    drain();
    set_regs(1023, 1023, 5, 10, 10, 8, 20);
    now_cursor = 32'hFFFF_FE00;
    gap_pct   = 0;
    stall_pct = 0;
    run_random(200, 8, 5, 1'b0);

    drain();
    set_regs(200, 0, 0, 0, 0, 0, 0);
    gap_pct   = 40;
    stall_pct = 10;
    run_random(150, 2, 3, 1'b0);

    drain();
    set_regs(900, 1000, 65535, 65535, 65535, 65535, 65535);
    gap_pct   = 15;
    stall_pct = 40;
    run_random(150, 30000, 4, 1'b0);

    drain();
    set_regs($urandom(), $urandom(), junk_high($urandom_range(40)),
             junk_high($urandom_range(40)), junk_high($urandom_range(40)),
             junk_high($urandom_range(40)), junk_high($urandom_range(1000)));
    gap_pct   = 30;
    stall_pct = 30;
    run_random(250, 12, 2, 1'b0);

    // Latch the interlock, then exercise the locked state
    drain();
    set_regs(450, 900, 50, 500, 500, 250, 1000);
    table_rows.push_back(dir_row(now_cursor + 1, 1, 1, 1, 0,
                                 ($urandom_range(1) != 0) ? 10'd1023 : 10'd0));
    table_rows.push_back(dir_row(now_cursor + 11, 0, 0, 0, 0, 10'd450));
    table_rows.push_back(dir_row(now_cursor + 1012, 0, 0, 0, 0, 10'd450));
    table_rows.push_back(dir_row(now_cursor + 1013, 1, 1, 1, 1, 10'd900));
    table_rows.push_back(dir_row(now_cursor + 2015, 0, 1, 0, 1, 10'd300));
    walk_rows();
    run_random(60, 400, 4, 1'b1);

    drain();
    cfg_write(REG_SLOW_FLASH, 0);
    run_random(50, 3, 4, 1'b1);

    drain();
    cfg_write(REG_SLOW_FLASH, 65535);
    run_random(50, 40000, 4, 1'b1);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dic_pkg.sv
sv/dic_ifs.sv
sv/debounced_interlock_controller.sv
sim/tb_top.sv
